>>> src/fsd_pkg.sv
// Shared constants, types and codes of the fair-share task dispatcher.
`timescale 1ns / 1ps

package fsd_pkg;

	// Table geometry
	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

	// Field widths
	localparam int OP_W       = 2;
	localparam int IN_SLOT_W  = 3;
	localparam int TIME_W     = 16;
	localparam int PRIO_W     = 4;
	localparam int VRT_W      = 24;
	localparam int SLICE_W    = 8;
	localparam int PROD_W     = TIME_W + PRIO_W;

	// Stream payload widths
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;

	// Configuration port
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TIME_SLICE = '0;
	localparam logic [SLICE_W-1:0]   TIME_SLICE_RST = 8'd2;

	// Operation codes carried on the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_LOAD     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_CALC = 5'b00100,
		ST_WB   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	// One task record as it is stored in the table memory
	typedef struct packed {
		logic [VRT_W-1:0]  vrt;
		logic [TIME_W-1:0] rem;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] arr;
	} task_rec_t;

endpackage

>>> src/fair_share_task_dispatcher.sv
// Top level of the fair-share task dispatcher: sequencer, task table and result register.
`timescale 1ns / 1ps

// Requests arrive on the s_ stream: tuser carries the operation (load, dispatch,
// clear) and tdata the slot, arrival, burst and priority of a load. Every request
// produces exactly one result on the m_ stream: tdata carries the chosen slot,
// run length, turnaround, waiting time and current time; tuser the idle, done and
// finished flags. The time slice register sits at APB address 0.
// Load, clear and unused requests pass through the finish state, which loads the
// output register once it is free, and the sequencer then returns to idle.
// A dispatch reads the eight table entries from the task memory one per cycle in
// the scan state, then passes through the calculate, write-back and finish states
// and returns to idle. One request is in work at a time.
// The next request is accepted as soon as the sequencer is idle, even while the
// previous result still waits in the output register. If the receiver stalls,
// a finished result waits in an internal stage until the output register frees.
// Reset clears all slots (through per-slot valid bits), the time, and sets the
// time slice to 2; the block is ready in the first cycle after reset.
module fair_share_task_dispatcher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tdata: task_slot[2:0], arrival[18:3], burst[34:19], prio_level[38:35]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [fsd_pkg::IN_DATA_W-1:0]        s_tdata,
	// s_tuser: operation[1:0]
	input  logic [fsd_pkg::OP_W-1:0]             s_tuser,
	// m_tdata: chosen_slot[2:0], run_length[18:3], turnaround[34:19],
	//          waiting[50:35], time_now[66:51]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [fsd_pkg::OUT_DATA_W-1:0]       m_tdata,
	// m_tuser: idle_flag[0], done_flag[1], finished_flag[2]
	output logic [fsd_pkg::OUT_USER_W-1:0]       m_tuser,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fsd_pkg::PADDR_W-1:0]          paddr,
	input  logic [fsd_pkg::PDATA_W-1:0]          pwdata,
	output logic [fsd_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);

	localparam int N      = fsd_pkg::TASK_SLOTS;
	localparam int SW     = fsd_pkg::SLOT_W;
	localparam int CW     = fsd_pkg::CNT_W;
	localparam int TW     = fsd_pkg::TIME_W;
	localparam int VW     = fsd_pkg::VRT_W;
	localparam int PW     = fsd_pkg::PRIO_W;
	localparam int RW     = $bits(fsd_pkg::task_rec_t);

	// Input field unpacking
	logic [fsd_pkg::IN_SLOT_W-1:0] in_slot;
	logic [TW-1:0]                 in_arr;
	logic [TW-1:0]                 in_burst;
	logic [PW-1:0]                 in_prio;
	logic                          in_acc;
	logic                          slot_ok;

	assign in_slot  = s_tdata[2:0];
	assign in_arr   = s_tdata[18:3];
	assign in_burst = s_tdata[34:19];
	assign in_prio  = s_tdata[38:35];
	assign in_acc   = s_tvalid && s_tready;
	assign slot_ok  = int'(in_slot) < N;

	// Control state
	fsd_pkg::state_t          state_q;
	logic [CW-1:0]            cnt_q;
	logic [N-1:0]             valid_q;
	logic [TW-1:0]            time_q;
	logic [fsd_pkg::SLICE_W-1:0] slice_q;
	logic                     out_vld_q;
	logic                     best_found_q;
	logic                     any_left_q;
	logic                     rd_vld_s1;

	// Payload registers
	logic [SW-1:0]            rd_slot_s1;
	logic [SW-1:0]            best_slot_q;
	logic [VW-1:0]            best_vrt_q;
	logic [TW-1:0]            best_rem_q;
	logic [TW-1:0]            best_arr_q;
	logic [TW-1:0]            best_burst_q;
	logic [PW-1:0]            best_prio_q;
	logic [TW-1:0]            soonest_arr_q;
	logic [TW-1:0]            run_q;
	logic [fsd_pkg::PROD_W-1:0] prod_q;
	logic [TW:0]              ab_sum_q;
	logic [SW-1:0]            res_slot_q;
	logic [TW-1:0]            res_run_q;
	logic                     res_idle_q;
	logic                     res_done_q;
	logic                     res_fin_q;
	logic [fsd_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [fsd_pkg::OUT_USER_W-1:0] out_user_q;

	// Task memory
	logic                     ram_we;
	logic [SW-1:0]            ram_waddr;
	fsd_pkg::task_rec_t       ram_wdata;
	logic [SW-1:0]            ram_raddr;
	fsd_pkg::task_rec_t       ram_rdata;

	fsd_ram #(
		.WIDTH (RW),
		.DEPTH (N)
	) u_task_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration port: one register, writes take effect in the access cycle.
	logic cfg_wr;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = paddr[fsd_pkg::PADDR_W-1:2] == fsd_pkg::REG_TIME_SLICE;
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? fsd_pkg::PDATA_W'(slice_q) : '0;

	// Scan evaluation of the entry read in the previous cycle.
	logic live_c;
	logic arrived_c;
	logic take_best_c;
	logic take_next_c;

	assign live_c      = rd_vld_s1 && valid_q[rd_slot_s1] && (ram_rdata.rem != '0);
	assign arrived_c   = ram_rdata.arr <= time_q;
	assign take_best_c = live_c && arrived_c
		&& (!best_found_q || (ram_rdata.vrt < best_vrt_q));
	assign take_next_c = live_c && !arrived_c
		&& (!any_left_q || (ram_rdata.arr < soonest_arr_q));

	// Run length and weight of the chosen task.
	logic [TW-1:0] slice_eff_c;
	logic [TW-1:0] run_c;
	logic [PW-1:0] weight_c;

	assign slice_eff_c = (slice_q == '0) ? TW'(1) : TW'(slice_q);
	assign run_c       = (best_rem_q < slice_eff_c) ? best_rem_q : slice_eff_c;
	assign weight_c    = (best_prio_q == '0) ? PW'(1) : best_prio_q;

	// Write-back values: saturating virtual runtime and time.
	logic [VW:0]   vrt_sum_c;
	logic [VW-1:0] vrt_new_c;
	logic [TW-1:0] rem_new_c;
	logic [TW:0]   time_sum_c;
	logic [TW-1:0] time_new_c;

	assign vrt_sum_c  = {1'b0, best_vrt_q} + (VW + 1)'(prod_q);
	assign vrt_new_c  = vrt_sum_c[VW] ? '1 : vrt_sum_c[VW-1:0];
	assign rem_new_c  = best_rem_q - run_q;
	assign time_sum_c = {1'b0, time_q} + {1'b0, run_q};
	assign time_new_c = time_sum_c[TW] ? '1 : time_sum_c[TW-1:0];

	// Memory port selection: load writes at acceptance, dispatch in write-back.
	logic load_wr;
	logic wb_wr;

	assign load_wr   = in_acc && (s_tuser == fsd_pkg::OP_LOAD) && slot_ok;
	assign wb_wr     = (state_q == fsd_pkg::ST_WB) && best_found_q;
	assign ram_we    = load_wr || wb_wr;
	assign ram_raddr = cnt_q[SW-1:0];

	always_comb begin
		ram_waddr = best_slot_q;
		ram_wdata = '{vrt: vrt_new_c, rem: rem_new_c, prio: best_prio_q,
			burst: best_burst_q, arr: best_arr_q};
		if (load_wr) begin
			ram_waddr = SW'(in_slot);
			ram_wdata = '{vrt: '0, rem: in_burst, prio: in_prio,
				burst: in_burst, arr: in_arr};
		end
	end

	// Turnaround and waiting time from the updated time.
	logic [TW-1:0] ta_c;
	logic [TW-1:0] wait_c;
	logic          load_out;

	assign ta_c     = res_fin_q ? (time_q - best_arr_q) : '0;
	assign wait_c   = (res_fin_q && ({1'b0, time_q} >= ab_sum_q))
		? (time_q - ab_sum_q[TW-1:0]) : '0;
	assign load_out = (state_q == fsd_pkg::ST_FIN) && (!out_vld_q || m_tready);

	assign s_tready = state_q == fsd_pkg::ST_IDLE;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fsd_pkg::ST_IDLE;
			cnt_q        <= '0;
			valid_q      <= '0;
			time_q       <= '0;
			slice_q      <= fsd_pkg::TIME_SLICE_RST;
			out_vld_q    <= 1'b0;
			best_found_q <= 1'b0;
			any_left_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				slice_q <= pwdata[fsd_pkg::SLICE_W-1:0];
			end
			rd_vld_s1 <= (state_q == fsd_pkg::ST_SCAN) && (cnt_q < CW'(N));
			// The output register empties unless a new result replaces it.
			if (out_vld_q && m_tready && !load_out) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				fsd_pkg::ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							fsd_pkg::OP_LOAD: begin
								state_q <= fsd_pkg::ST_FIN;
								if (slot_ok) begin
									valid_q[SW'(in_slot)] <= 1'b1;
								end
							end
							fsd_pkg::OP_DISPATCH: begin
								state_q      <= fsd_pkg::ST_SCAN;
								cnt_q        <= '0;
								best_found_q <= 1'b0;
								any_left_q   <= 1'b0;
							end
							fsd_pkg::OP_CLEAR: begin
								state_q <= fsd_pkg::ST_FIN;
								valid_q <= '0;
								time_q  <= '0;
							end
							default: begin
								state_q <= fsd_pkg::ST_FIN;
							end
						endcase
					end
				end
				fsd_pkg::ST_SCAN: begin
					if (cnt_q < CW'(N)) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= fsd_pkg::ST_CALC;
					end
					if (take_best_c) begin
						best_found_q <= 1'b1;
					end
					if (take_next_c) begin
						any_left_q <= 1'b1;
					end
				end
				fsd_pkg::ST_CALC: begin
					state_q <= fsd_pkg::ST_WB;
				end
				fsd_pkg::ST_WB: begin
					state_q <= fsd_pkg::ST_FIN;
					if (best_found_q) begin
						time_q <= time_new_c;
					end else if (any_left_q) begin
						time_q <= soonest_arr_q;
					end
				end
				fsd_pkg::ST_FIN: begin
					if (load_out) begin
						out_vld_q <= 1'b1;
						state_q   <= fsd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fsd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: scan candidates, run arithmetic and result staging.
	always_ff @(posedge clk) begin
		rd_slot_s1 <= cnt_q[SW-1:0];
		if (in_acc) begin
			res_slot_q <= '0;
			res_run_q  <= '0;
			res_idle_q <= 1'b0;
			res_done_q <= 1'b0;
			res_fin_q  <= 1'b0;
		end
		if (take_best_c) begin
			best_slot_q  <= rd_slot_s1;
			best_vrt_q   <= ram_rdata.vrt;
			best_rem_q   <= ram_rdata.rem;
			best_arr_q   <= ram_rdata.arr;
			best_burst_q <= ram_rdata.burst;
			best_prio_q  <= ram_rdata.prio;
		end
		if (take_next_c) begin
			soonest_arr_q <= ram_rdata.arr;
		end
		if (state_q == fsd_pkg::ST_CALC) begin
			run_q    <= run_c;
			prod_q   <= run_c * weight_c;
			ab_sum_q <= {1'b0, best_arr_q} + {1'b0, best_burst_q};
		end
		if (state_q == fsd_pkg::ST_WB) begin
			if (best_found_q) begin
				res_slot_q <= best_slot_q;
				res_run_q  <= run_q;
				res_fin_q  <= rem_new_c == '0;
			end else if (any_left_q) begin
				res_run_q  <= soonest_arr_q - time_q;
				res_idle_q <= 1'b1;
			end else begin
				res_done_q <= 1'b1;
			end
		end
		if (load_out) begin
			out_data_q <= {5'b0, time_q, wait_c, ta_c, res_run_q,
				fsd_pkg::IN_SLOT_W'(res_slot_q)};
			out_user_q <= {res_fin_q, res_done_q, res_idle_q};
		end
	end

	// An accepted request always leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != fsd_pkg::ST_IDLE)
		else $error("accepted request did not start the sequencer");

	// The scan counter never runs past the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsd_pkg::ST_SCAN) |-> (cnt_q <= CW'(N)))
		else $error("scan counter overran the table");

	// No memory write may disturb a scan in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsd_pkg::ST_SCAN) |-> !ram_we)
		else $error("task memory written during scan");

	// A chosen task runs at least one tick and no longer than it has left.
	assert property (@(posedge clk) disable iff (!arst_n)
		wb_wr |-> ((run_q != '0) && (run_q <= best_rem_q)))
		else $error("run length out of range");

	// A clear request returns the time to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_tuser == fsd_pkg::OP_CLEAR)) |=> (time_q == '0))
		else $error("clear did not reset the time");

endmodule

>>> src/fsd_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the fair-share task dispatcher: directed table, random episodes.
`timescale 1ns / 1ps

module tb_top;

	// Operation code that the block must ignore.
	localparam logic [fsd_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PHASE_REQUESTS = 222;

	// One result as the bench sees it, fields in reading order.
	typedef struct packed {
		logic [2:0]  slot;
		logic [15:0] run;
		logic        idle;
		logic        done;
		logic        fin;
		logic [15:0] ta;
		logic [15:0] wt;
		logic [15:0] now;
	} outcome_t;

	// One row of the directed table.
	typedef struct {
		logic [fsd_pkg::OP_W-1:0] op;
		logic [2:0]      slot;
		logic [15:0]     arr;
		logic [15:0]     bur;
		logic [3:0]      pr;
		bit              typed;
		outcome_t        want;
	} drill_row_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [fsd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [fsd_pkg::OP_W-1:0]       s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b1;
	logic [fsd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [fsd_pkg::OUT_USER_W-1:0] m_tuser;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [fsd_pkg::PADDR_W-1:0]    paddr = '0;
	logic [fsd_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [fsd_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	// Shadow copy of the task table, time and slice register.
	logic [15:0]                 arr_tab   [fsd_pkg::TASK_SLOTS];
	logic [15:0]                 burst_tab [fsd_pkg::TASK_SLOTS];
	logic [3:0]                  prio_tab  [fsd_pkg::TASK_SLOTS];
	logic [15:0]                 rem_tab   [fsd_pkg::TASK_SLOTS] = '{default: '0};
	logic [fsd_pkg::VRT_W-1:0]   vrt_tab   [fsd_pkg::TASK_SLOTS] = '{default: '0};
	logic [15:0]                 now_tick = '0;
	logic [fsd_pkg::SLICE_W-1:0] slice_now = fsd_pkg::TIME_SLICE_RST;

	outcome_t     pending_outcomes[$];
	outcome_t     last_outcome;
	drill_row_t   drill_q[$];
	int unsigned  requests_sent = 0;
	int unsigned  error_count = 0;
	logic         hold_results = 1'b0;
	int unsigned  tx_calm_left = 0;
	bit           tx_calm = 0;

	fair_share_task_dispatcher DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Advances the shadow scheduler by one request and returns its result.
	function automatic outcome_t compute_outcome(logic [fsd_pkg::OP_W-1:0] op,
			logic [2:0] slot, logic [15:0] arr, logic [15:0] bur, logic [3:0] pr);
		outcome_t    o;
		int          best;
		int          i;
		bit          later;
		logic [15:0] soonest_arr;
		logic [15:0] ta;
		int unsigned run;
		int unsigned weight;
		int unsigned vsum;
		int unsigned tsum;
		o = '0;
		best = -1;
		later = 0;
		soonest_arr = '0;
		case (op)
			fsd_pkg::OP_LOAD: begin
				if (slot < fsd_pkg::TASK_SLOTS) begin
					arr_tab[slot] = arr;
					burst_tab[slot] = bur;
					prio_tab[slot] = pr;
					rem_tab[slot] = bur;
					vrt_tab[slot] = '0;
				end
			end
			fsd_pkg::OP_DISPATCH: begin
				// Least virtual runtime among arrived tasks, earliest arrival among the rest.
				for (i = 0; i < fsd_pkg::TASK_SLOTS; i++) begin
					if (rem_tab[i] != 0) begin
						if (arr_tab[i] <= now_tick) begin
							if (best < 0 || vrt_tab[i] < vrt_tab[best])
								best = i;
						end else begin
							if (!later || arr_tab[i] < soonest_arr)
								soonest_arr = arr_tab[i];
							later = 1;
						end
					end
				end
				if (best >= 0) begin
					run = (slice_now == 0) ? 1 : slice_now;
					if (rem_tab[best] < run)
						run = rem_tab[best];
					weight = (prio_tab[best] == 0) ? 1 : prio_tab[best];
					vsum = vrt_tab[best] + run * weight;
					vrt_tab[best] = (vsum > 32'hFF_FFFF) ? 24'hFF_FFFF : vsum[23:0];
					rem_tab[best] = rem_tab[best] - run[15:0];
					tsum = now_tick + run;
					now_tick = (tsum > 32'hFFFF) ? 16'hFFFF : tsum[15:0];
					o.slot = best[2:0];
					o.run = run[15:0];
					if (rem_tab[best] == 0) begin
						// Waiting time is clamped when the clock has saturated.
						ta = now_tick - arr_tab[best];
						o.fin = 1'b1;
						o.ta = ta;
						o.wt = (ta >= burst_tab[best]) ? ta - burst_tab[best] : 16'd0;
					end
				end else if (later) begin
					o.run = soonest_arr - now_tick;
					o.idle = 1'b1;
					now_tick = soonest_arr;
				end else begin
					o.done = 1'b1;
				end
			end
			fsd_pkg::OP_CLEAR: begin
				for (i = 0; i < fsd_pkg::TASK_SLOTS; i++) begin
					rem_tab[i] = '0;
					vrt_tab[i] = '0;
				end
				now_tick = '0;
			end
			default: ;
		endcase
		o.now = now_tick;
		return o;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic void add_drill(logic [fsd_pkg::OP_W-1:0] op, logic [2:0] slot,
			logic [15:0] arr, logic [15:0] bur, logic [3:0] pr, bit typed, outcome_t want);
		drill_row_t row;
		row.op = op;
		row.slot = slot;
		row.arr = arr;
		row.bur = bur;
		row.pr = pr;
		row.typed = typed;
		row.want = want;
		drill_q.insert(drill_q.size(), row);
	endfunction

	// Offers one request after a random gap and records its expected result.
	task automatic send_request(logic [fsd_pkg::OP_W-1:0] op, logic [2:0] slot,
			logic [15:0] arr, logic [15:0] bur, logic [3:0] pr, bit typed, outcome_t want);
		int unsigned gap;
		outcome_t    o;
		if (tx_calm_left == 0) begin
			tx_calm = ($urandom_range(0, 2) == 0);
			tx_calm_left = $urandom_range(10, 40);
		end
		tx_calm_left--;
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, pr, bur, arr, slot};
		do @(posedge clk); while (!s_tready);
		o = compute_outcome(op, slot, arr, bur, pr);
		pending_outcomes.insert(pending_outcomes.size(), typed ? want : o);
		last_outcome = o;
		requests_sent++;
	endtask

	// Loads one slot with mostly short bursts and early arrivals.
	task automatic random_load();
		logic [15:0] arr;
		logic [15:0] bur;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		arr = (pick < 85) ? 16'($urandom_range(0, 30)) : 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 8)
			bur = '0;
		else if (pick < 75)
			bur = 16'($urandom_range(1, 10));
		else if (pick < 95)
			bur = 16'($urandom_range(11, 300));
		else
			bur = 16'($urandom_range(1, 65535));
		send_request(fsd_pkg::OP_LOAD, 3'($urandom_range(0, 7)), arr, bur,
			4'($urandom_range(0, 15)), 1'b0, '0);
	endtask

	task automatic random_junk(logic [fsd_pkg::OP_W-1:0] op);
		send_request(op, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), 1'b0, '0);
	endtask

	// Mostly clear, load and dispatch-until-done episodes, with some noise.
	task automatic run_phase(int unsigned budget);
		int unsigned start;
		int unsigned loads;
		int unsigned k;
		start = requests_sent;
		while (requests_sent - start < budget) begin
			if ($urandom_range(0, 99) < 8) begin
				random_junk(2'($urandom_range(0, 3)));
			end else begin
				if ($urandom_range(0, 9) != 0)
					random_junk(fsd_pkg::OP_CLEAR);
				loads = $urandom_range(1, 8);
				repeat (loads) random_load();
				k = 0;
				do begin
					if ($urandom_range(0, 24) == 0)
						random_load();
					random_junk(fsd_pkg::OP_DISPATCH);
					k++;
				end while (!last_outcome.done && k < 60);
			end
		end
	endtask

	// Waits until every expected result has come back and the block is quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_slice(logic [fsd_pkg::SLICE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {fsd_pkg::REG_TIME_SLICE, 2'b00};
		pwdata <= {{(fsd_pkg::PDATA_W - fsd_pkg::SLICE_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		slice_now = value;
	endtask

	// Result side: random stalls, then compare against the oldest expectation.
	initial begin : result_check
		int unsigned gap;
		int unsigned calm_left;
		bit          calm;
		outcome_t    got;
		outcome_t    want;
		calm_left = 0;
		calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				calm_left = $urandom_range(10, 40);
			end
			calm_left--;
			gap = calm ? 0 : $urandom_range(0, 4);
			if (gap != 0 || hold_results) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_results) @(posedge clk);
				m_tready <= 1'b1;
			end
			do @(posedge clk); while (!m_tvalid);
			got = '{m_tdata[2:0], m_tdata[18:3], m_tuser[0], m_tuser[1], m_tuser[2],
				m_tdata[34:19], m_tdata[50:35], m_tdata[66:51]};
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: result with none expected, actual %h", $time, got);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("chosen_slot", want.slot, got.slot);
				compare_field("run_length", want.run, got.run);
				compare_field("idle_flag", want.idle, got.idle);
				compare_field("done_flag", want.done, got.done);
				compare_field("finished_flag", want.fin, got.fin);
				compare_field("turnaround", want.ta, got.ta);
				compare_field("waiting", want.wt, got.wt);
				compare_field("time_now", want.now, got.now);
			end
		end
	end

	// Long receiver stall so the block fills up and holds off new requests.
	initial begin : output_backpressure
		wait (requests_sent >= 200);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (300) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin : stimulus
		int i;
		// Directed table, slice at its reset value of two.
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'd0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0});
		add_drill(OP_SPARE, 3'd7, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd0, 16'd0, 16'd3, 4'd0, 1'b1, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd7, 16'd5, 16'hFFFF, 4'd15, 1'b1, '0);
		// A zero burst leaves the slot empty.
		add_drill(fsd_pkg::OP_LOAD, 3'd3, 16'd0, 16'd0, 4'd7, 1'b1, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'd2, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd2});
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'd1, 1'b0, 1'b0, 1'b1, 16'd3, 16'd0, 16'd3});
		// Nothing ready: the clock jumps to the next arrival.
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'd2, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd5});
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd1, 16'd0, 16'd1, 4'd1, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd5, 16'hFFFF, 16'hFFFF, 4'hF, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_CLEAR, 3'd6, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'd0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0});
		// Late arrivals drive the clock into saturation; equal runtimes pick the lower slot.
		add_drill(fsd_pkg::OP_LOAD, 3'd2, 16'hFFFF, 16'hFFFF, 4'd15, 1'b0, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd4, 16'hFFFE, 16'd4, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd5, 16'hFFFE, 16'd2, 4'd1, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1,
			'{3'd0, 16'hFFFE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFE});
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0, 4'd0, 1'b0, '0);
		add_drill(fsd_pkg::OP_LOAD, 3'd6, 16'd0, 16'd1, 4'd8, 1'b0, '0);
		add_drill(fsd_pkg::OP_CLEAR, 3'd0, 16'd0, 16'd0, 4'd0, 1'b1, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < drill_q.size(); i++)
			send_request(drill_q[i].op, drill_q[i].slot, drill_q[i].arr, drill_q[i].bur,
				drill_q[i].pr, drill_q[i].typed, drill_q[i].want);
		settle();

		// Random phases over several slice settings, extremes and zero among them.
		write_slice(8'd1);
		run_phase(PHASE_REQUESTS);
		settle();
		write_slice(8'd255);
		run_phase(PHASE_REQUESTS);
		settle();
		write_slice(8'd0);
		run_phase(PHASE_REQUESTS);
		settle();
		write_slice(8'($urandom_range(3, 254)));
		run_phase(PHASE_REQUESTS);
		settle();
		write_slice(8'($urandom_range(1, 8)));
		run_phase(PHASE_REQUESTS);
		settle();
		write_slice(fsd_pkg::TIME_SLICE_RST);
		run_phase(PHASE_REQUESTS);
		settle();

		if (error_count == 0 && pending_outcomes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
src/fsd_pkg.sv
src/fsd_ram.sv
src/fair_share_task_dispatcher.sv
bench/tb_top.sv
